// ----- hdl/lapn_pkg.sv -----
// Shared types and constants for the LIF neuron step block.
// Request structs, configuration register set, register map and reset values.
// No dependencies.
package lapn_pkg;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef struct packed {
        logic        [30:0] syn_weight_in;
        logic signed [31:0] noise_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] membrane_potential;
        logic               spike;
    } t_out_req;

    typedef struct packed {
        logic        [24:0] syn_decay;
        logic        [30:0] current_to_psp_gain;
        logic        [24:0] ahp_decay;
        logic signed [31:0] fire_threshold;
        logic        [30:0] reset_step;
        logic        [30:0] noise_gain;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_SYN_DECAY      = 3'd0,
        REG_CUR_PSP_GAIN   = 3'd1,
        REG_AHP_DECAY      = 3'd2,
        REG_FIRE_THRESHOLD = 3'd3,
        REG_RESET_STEP     = 3'd4,
        REG_NOISE_GAIN     = 3'd5
    } t_reg_idx;

    localparam logic        [24:0] RST_SYN_DECAY      = 25'd16580993;
    localparam logic        [30:0] RST_CUR_PSP_GAIN   = 31'd408290;
    localparam logic        [24:0] RST_AHP_DECAY      = 25'd16668626;
    localparam logic signed [31:0] RST_FIRE_THRESHOLD = 32'sd16777216;
    localparam logic        [30:0] RST_RESET_STEP     = 31'd38755369;
    localparam logic        [30:0] RST_NOISE_GAIN     = 31'd0;

endpackage

// ----- hdl/lif_alpha_psp_neuron_step.sv -----
// Top level of the LIF neuron step block with alpha-shaped synaptic response.
// Depends on lapn_pkg, lapn_regs, lapn_front, lapn_core.
//
// Usage:
//   One request on the input channel is one simulation tick: summed excitatory
//   weight and a noise sample. Each request gives exactly one result request:
//   the membrane potential after the tick and a spike flag.
//   Both channels use valid/stall; a request moves when valid is high and
//   stall is low. Coefficients are written over the APB port while no tick is
//   in flight; pready is tied high and reads return the register value.
//   A request passes through the input register, the noise scaling register
//   and the result register. Throughput: one tick per cycle unless the
//   receiver stalls; the state recurrence closes through one multiply level
//   and the saturating add chain in the core stage.
//   Receiver stall: the result register holds, the stages behind it fill, and
//   the input stall rises only once all three are full.
//   Reset: pipeline emptied, neuron state cleared to zero, registers return
//   to their default coefficients.
module lif_alpha_psp_neuron_step #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  lapn_pkg::t_in_req                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lapn_pkg::t_out_req                   o_out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lapn_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lapn_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lapn_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import lapn_pkg::*;

    t_cfg                        w_cfg;
    logic                        w_mid_valid;
    logic                        w_mid_ready;
    logic signed [WORD_BITS-1:0] w_weight;
    logic signed [WORD_BITS-1:0] w_noise_scaled;

    lapn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lapn_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_data         (i_in_data),
        .i_noise_gain   (w_cfg.noise_gain),
        .o_valid        (w_mid_valid),
        .i_ready        (w_mid_ready),
        .o_weight       (w_weight),
        .o_noise_scaled (w_noise_scaled)
    );

    lapn_core #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (w_mid_valid),
        .o_ready        (w_mid_ready),
        .i_weight       (w_weight),
        .i_noise_scaled (w_noise_scaled),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule

// ----- hdl/lapn_fx_mul.sv -----
// Fixed-point multiply: signed word times unsigned coefficient, rounded, saturated.
// Purely combinational. No package dependencies.
module lapn_fx_mul #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24,
    parameter int COEF_BITS = 25
) (
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic        [COEF_BITS-1:0] i_b,
    output logic signed [WORD_BITS-1:0] o_p
);
    localparam int PW = WORD_BITS + COEF_BITS + 1;
    localparam logic [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] LIM_POS = (PW'(1) << (WORD_BITS - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (WORD_BITS - 1);

    logic                 w_neg;
    logic [WORD_BITS-1:0] w_mag;
    logic [PW-1:0]        w_rnd;
    logic [PW-1:0]        w_prod;
    logic [PW-1:0]        w_shift;
    logic [PW-1:0]        w_lim;
    logic [PW-1:0]        w_clip;
    logic [WORD_BITS-1:0] w_res;

    // magnitude of the most negative word reads correctly as unsigned
    assign w_neg   = i_a[WORD_BITS-1];
    assign w_mag   = w_neg ? WORD_BITS'(-i_a) : WORD_BITS'(i_a);
    // ties go toward plus infinity on both signs
    assign w_rnd   = w_neg ? (HALF - PW'(1)) : HALF;
    assign w_prod  = PW'(w_mag) * PW'(i_b) + w_rnd;
    assign w_shift = w_prod >> FRAC_BITS;
    assign w_lim   = w_neg ? LIM_NEG : LIM_POS;
    assign w_clip  = (w_shift > w_lim) ? w_lim : w_shift;
    assign w_res   = w_clip[WORD_BITS-1:0];
    assign o_p     = w_neg ? $signed(-w_res) : $signed(w_res);

endmodule

// ----- hdl/lapn_regs.sv -----
// APB configuration registers of the neuron step block.
// Depends on lapn_pkg (t_cfg, t_reg_idx, reset values).
module lapn_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lapn_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lapn_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lapn_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output lapn_pkg::t_cfg                       o_cfg
);
    import lapn_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.syn_decay           <= RST_SYN_DECAY;
            r_cfg.current_to_psp_gain <= RST_CUR_PSP_GAIN;
            r_cfg.ahp_decay           <= RST_AHP_DECAY;
            r_cfg.fire_threshold      <= RST_FIRE_THRESHOLD;
            r_cfg.reset_step          <= RST_RESET_STEP;
            r_cfg.noise_gain          <= RST_NOISE_GAIN;
        end else if (w_wr) begin
            case (w_idx)
                REG_SYN_DECAY:      r_cfg.syn_decay           <= pwdata[24:0];
                REG_CUR_PSP_GAIN:   r_cfg.current_to_psp_gain <= pwdata[30:0];
                REG_AHP_DECAY:      r_cfg.ahp_decay           <= pwdata[24:0];
                REG_FIRE_THRESHOLD: r_cfg.fire_threshold      <= $signed(pwdata[31:0]);
                REG_RESET_STEP:     r_cfg.reset_step          <= pwdata[30:0];
                REG_NOISE_GAIN:     r_cfg.noise_gain          <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SYN_DECAY:      prdata = APB_DATA_BITS'(r_cfg.syn_decay);
            REG_CUR_PSP_GAIN:   prdata = APB_DATA_BITS'(r_cfg.current_to_psp_gain);
            REG_AHP_DECAY:      prdata = APB_DATA_BITS'(r_cfg.ahp_decay);
            REG_FIRE_THRESHOLD: prdata = APB_DATA_BITS'(unsigned'(r_cfg.fire_threshold));
            REG_RESET_STEP:     prdata = APB_DATA_BITS'(r_cfg.reset_step);
            REG_NOISE_GAIN:     prdata = APB_DATA_BITS'(r_cfg.noise_gain);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- hdl/lapn_front.sv -----
// Input register and noise scaling stage of the neuron step block.
// Depends on lapn_pkg (t_in_req) and lapn_fx_mul.
module lapn_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  lapn_pkg::t_in_req           i_data,
    input  logic [30:0]                 i_noise_gain,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_weight,
    output logic signed [WORD_BITS-1:0] o_noise_scaled
);
    import lapn_pkg::*;

    localparam int EXT = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam logic signed [EXT-1:0] WMAX_X =
        {{(EXT-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [EXT-1:0] WMIN_X =
        {{(EXT-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [EXT-1:0] v
    );
        if (v > WMAX_X) return WMAX_X[WORD_BITS-1:0];
        if (v < WMIN_X) return WMIN_X[WORD_BITS-1:0];
        return v[WORD_BITS-1:0];
    endfunction

    logic                        r_in_v;
    t_in_req                     r_in;
    logic                        r_s1_v;
    logic signed [WORD_BITS-1:0] r_weight;
    logic signed [WORD_BITS-1:0] r_noise_scaled;

    logic                        w_in_ready;
    logic                        w_s1_ready;
    logic signed [WORD_BITS-1:0] w_noise;
    logic signed [WORD_BITS-1:0] w_noise_scaled;

    // each stage moves when the one after it is empty or moving
    assign w_s1_ready = !r_s1_v || i_ready;
    assign w_in_ready = !r_in_v || w_s1_ready;
    assign o_stall    = !w_in_ready;

    assign w_noise = sat_word(EXT'(r_in.noise_sample));

    lapn_fx_mul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .COEF_BITS (31)
    ) u_noise_mul (
        .i_a (w_noise),
        .i_b (i_noise_gain),
        .o_p (w_noise_scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_v <= i_valid;
            end
            if (w_s1_ready) begin
                r_s1_v <= r_in_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_in_ready) begin
            r_in <= i_data;
        end
        if (r_in_v && w_s1_ready) begin
            r_weight       <= sat_word($signed(EXT'(r_in.syn_weight_in)));
            r_noise_scaled <= w_noise_scaled;
        end
    end

    assign o_valid        = r_s1_v;
    assign o_weight       = r_weight;
    assign o_noise_scaled = r_noise_scaled;

endmodule

// ----- hdl/lapn_core.sv -----
// Neuron state update, threshold test and result register.
// Depends on lapn_pkg (t_cfg, t_out_req) and lapn_fx_mul.
module lapn_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lapn_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [WORD_BITS-1:0] i_weight,
    input  logic signed [WORD_BITS-1:0] i_noise_scaled,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lapn_pkg::t_out_req          o_out_data
);
    import lapn_pkg::*;

    localparam int EXT = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [EXT-1:0] WMAX_X =
        {{(EXT-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};

    function automatic logic signed [WORD_BITS-1:0] sat_add(
        input logic signed [WORD_BITS-1:0] a,
        input logic signed [WORD_BITS-1:0] b,
        input logic                        sub
    );
        logic signed [WORD_BITS:0] s;
        s = sub ? ((WORD_BITS+1)'(a) - (WORD_BITS+1)'(b))
                : ((WORD_BITS+1)'(a) + (WORD_BITS+1)'(b));
        if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? W_MIN : W_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    logic signed [WORD_BITS-1:0] r_cur;
    logic signed [WORD_BITS-1:0] r_psp;
    logic signed [WORD_BITS-1:0] r_ahp;
    logic                        r_out_v;
    t_out_req                    r_out;

    logic signed [WORD_BITS-1:0] w_psp_dec;
    logic signed [WORD_BITS-1:0] w_cur_gain;
    logic signed [WORD_BITS-1:0] w_cur_dec;
    logic signed [WORD_BITS-1:0] w_ahp_dec;
    logic signed [WORD_BITS-1:0] w_rst;
    logic signed [EXT-1:0]       w_rst_x;
    logic signed [WORD_BITS-1:0] n_psp;
    logic signed [WORD_BITS-1:0] n_cur;
    logic signed [WORD_BITS-1:0] n_ahp;
    logic signed [WORD_BITS-1:0] w_mem_a;
    logic signed [WORD_BITS-1:0] w_mem0;
    logic signed [WORD_BITS-1:0] w_mem;
    logic signed [EXT-1:0]       w_mem_x;
    logic                        w_spike;
    logic                        w_take;

    // all four products use last tick's state
    lapn_fx_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .COEF_BITS(25))
        u_psp_dec (.i_a(r_psp), .i_b(i_cfg.syn_decay), .o_p(w_psp_dec));
    lapn_fx_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .COEF_BITS(31))
        u_cur_gain (.i_a(r_cur), .i_b(i_cfg.current_to_psp_gain), .o_p(w_cur_gain));
    lapn_fx_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .COEF_BITS(25))
        u_cur_dec (.i_a(r_cur), .i_b(i_cfg.syn_decay), .o_p(w_cur_dec));
    lapn_fx_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .COEF_BITS(25))
        u_ahp_dec (.i_a(r_ahp), .i_b(i_cfg.ahp_decay), .o_p(w_ahp_dec));

    assign w_rst_x = $signed(EXT'(i_cfg.reset_step));
    assign w_rst   = (w_rst_x > WMAX_X) ? W_MAX : w_rst_x[WORD_BITS-1:0];

    assign n_psp   = sat_add(w_psp_dec, w_cur_gain, 1'b0);
    assign n_cur   = sat_add(w_cur_dec, i_weight, 1'b0);
    assign w_mem_a = sat_add(n_psp, w_ahp_dec, 1'b0);
    assign w_mem0  = sat_add(w_mem_a, i_noise_scaled, 1'b0);
    assign w_spike = EXT'(w_mem0) >= EXT'(i_cfg.fire_threshold);
    assign n_ahp   = w_spike ? sat_add(w_ahp_dec, w_rst, 1'b1) : w_ahp_dec;
    assign w_mem   = w_spike ? sat_add(w_mem0, w_rst, 1'b1) : w_mem0;
    assign w_mem_x = EXT'(w_mem);

    assign o_ready = !r_out_v || !i_out_stall;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_psp   <= '0;
            r_ahp   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_v <= i_valid;
            end
            if (w_take) begin
                r_cur <= n_cur;
                r_psp <= n_psp;
                r_ahp <= n_ahp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.membrane_potential <= w_mem_x[31:0];
            r_out.spike              <= w_spike;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/lapn_checker.sv -----
// Port-level checks for the neuron step block, bound to the top level.
// Depends on lapn_pkg (request types) and lif_alpha_psp_neuron_step.
module lapn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lapn_pkg::t_out_req o_out_data
);
    import lapn_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input back-pressure only when the result side is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result side free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind lif_alpha_psp_neuron_step lapn_checker u_lapn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- sim/lif_alpha_psp_neuron_step_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lif_alpha_psp_neuron_step: neuron ticks under random gaps and
// back-pressure, coefficients written and read back over APB, results checked in order.
// Depends on lapn_pkg and the block RTL.
module lif_alpha_psp_neuron_step_tb;
    import lapn_pkg::*;

    localparam int          FRAC        = 24;
    localparam longint      WORD_HI     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      WORD_LO     = -64'sh0000_0000_8000_0000;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_TICKS = 180;
    localparam logic [30:0] WEIGHT_MAX  = '1;
    localparam logic [31:0] NOISE_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] NOISE_MIN   = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE_Q24     = 32'h0100_0000;
    // register slots past the end of the map
    localparam logic [4:0]  ADDR_SPARE_A = 5'd24;
    localparam logic [4:0]  ADDR_SPARE_B = 5'd28;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_req    i_in_data;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_req   o_out_data;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic       pready;

    // predictor state and coefficient copy
    t_cfg       cfg;
    longint     syn_cur;
    longint     psp_v;
    longint     ahp_v;
    t_out_req   membrane_exp_q[$];

    bit         gaps_on = 1'b1;
    int         err_count = 0;
    int         cycle_count = 0;

    lif_alpha_psp_neuron_step #(
        .WORD_BITS (32),
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp_word(longint x);
        if (x > WORD_HI) begin
            return WORD_HI;
        end
        if (x < WORD_LO) begin
            return WORD_LO;
        end
        return x;
    endfunction

    // signed word times unsigned coefficient, round half up, saturate
    function automatic longint mul_coef(longint a, longint unsigned b);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   lim;
        longint unsigned   r;
        neg = (a < 0);
        mag = neg ? longint'(-a) : longint'(a);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        r = (mag * b + (neg ? (64'd1 << (FRAC - 1)) - 64'd1 : (64'd1 << (FRAC - 1)))) >> FRAC;
        if (r > lim) begin
            r = lim;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_out_req neuron_tick(t_in_req req);
        longint   noise_scaled;
        longint   memb;
        longint   thr;
        t_out_req res;
        psp_v = clamp_word(mul_coef(psp_v, cfg.syn_decay)
                           + mul_coef(syn_cur, cfg.current_to_psp_gain));
        syn_cur = clamp_word(mul_coef(syn_cur, cfg.syn_decay) + longint'(req.syn_weight_in));
        ahp_v = mul_coef(ahp_v, cfg.ahp_decay);
        noise_scaled = mul_coef(longint'($signed(req.noise_sample)), cfg.noise_gain);
        memb = clamp_word(clamp_word(psp_v + ahp_v) + noise_scaled);
        thr = longint'($signed(cfg.fire_threshold));
        res.spike = 1'b0;
        if (memb >= thr) begin
            ahp_v = clamp_word(ahp_v - longint'(cfg.reset_step));
            memb = clamp_word(memb - longint'(cfg.reset_step));
            res.spike = 1'b1;
        end
        res.membrane_potential = memb[31:0];
        return res;
    endfunction

    function automatic t_in_req mk_tick(logic [30:0] w, logic [31:0] n);
        t_in_req req;
        req.syn_weight_in = w;
        req.noise_sample = n;
        return req;
    endfunction

    function automatic logic [4:0] reg_addr(t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    // mostly plausible neuron input, with zeros, full-range words and extremes mixed in
    function automatic t_in_req rand_tick();
        t_in_req     req;
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0: req.syn_weight_in = '0;
            1: req.syn_weight_in = 31'($urandom());
            2: req.syn_weight_in = WEIGHT_MAX;
            default: req.syn_weight_in = 31'($urandom_range(0, 32'h0200_0000));
        endcase
        k = $urandom_range(0, 9);
        case (k)
            6: req.noise_sample = $urandom();
            7: req.noise_sample = $urandom_range(0, 1) ? NOISE_MAX : NOISE_MIN;
            8, 9: req.noise_sample = '0;
            default: req.noise_sample = 32'($urandom_range(0, 32'h0200_0000)) - ONE_Q24;
        endcase
        return req;
    endfunction

    function automatic logic [31:0] pick_coef(t_reg_idx idx);
        int unsigned k;
        k = $urandom_range(0, 7);
        case (idx)
            REG_SYN_DECAY, REG_AHP_DECAY: begin
                if (k == 0) return '0;
                if (k == 1) return ALL_ONES;
                if (k == 2) return ONE_Q24;
                return $urandom_range(15_500_000, 16_777_216);
            end
            REG_CUR_PSP_GAIN: begin
                if (k == 0) return '0;
                if (k == 1) return NOISE_MAX;
                return $urandom_range(0, 4_000_000);
            end
            REG_FIRE_THRESHOLD: begin
                if (k == 0) return NOISE_MIN;
                if (k == 1) return NOISE_MAX;
                return 32'($urandom_range(0, 32'h0400_0000)) - ONE_Q24;
            end
            REG_RESET_STEP: begin
                if (k == 0) return '0;
                if (k == 1) return NOISE_MAX;
                return $urandom_range(0, 32'h0400_0000);
            end
            default: begin
                if (k == 0) return '0;
                if (k == 1) return NOISE_MAX;
                return $urandom_range(0, 32'h0080_0000);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic send_tick(input t_in_req req);
        while (gaps_on && $urandom_range(0, 99) < 17) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        membrane_exp_q.push_back(neuron_tick(req));
    endtask

    // stop sending and wait for every pending result
    task automatic drain_ticks();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (membrane_exp_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write, then read back the same slot
    task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
        logic [31:0] want;
        logic        mapped;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mapped = 1'b1;
        want = '0;
        case (addr[4:2])
            REG_SYN_DECAY: begin
                cfg.syn_decay = value[24:0];
                want = 32'(cfg.syn_decay);
            end
            REG_CUR_PSP_GAIN: begin
                cfg.current_to_psp_gain = value[30:0];
                want = 32'(cfg.current_to_psp_gain);
            end
            REG_AHP_DECAY: begin
                cfg.ahp_decay = value[24:0];
                want = 32'(cfg.ahp_decay);
            end
            REG_FIRE_THRESHOLD: begin
                cfg.fire_threshold = value;
                want = cfg.fire_threshold;
            end
            REG_RESET_STEP: begin
                cfg.reset_step = value[30:0];
                want = 32'(cfg.reset_step);
            end
            REG_NOISE_GAIN: begin
                cfg.noise_gain = value[30:0];
                want = 32'(cfg.noise_gain);
            end
            default: mapped = 1'b0;
        endcase
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (mapped && prdata !== want) begin
            report_mismatch("register readback", prdata, want);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_default_coefficients();
        send_tick(mk_tick('0, '0));
        send_tick(mk_tick(WEIGHT_MAX, NOISE_MAX));
        repeat (3) send_tick(mk_tick(WEIGHT_MAX, NOISE_MIN));
        repeat (2) send_tick(mk_tick('0, '0));
    endtask

    task automatic test_coefficient_extremes();
        // lowest threshold: every tick fires, noise at full scale
        drain_ticks();
        write_reg(reg_addr(REG_NOISE_GAIN), NOISE_MAX);
        write_reg(reg_addr(REG_FIRE_THRESHOLD), NOISE_MIN);
        write_reg(reg_addr(REG_RESET_STEP), ALL_ONES);
        write_reg(reg_addr(REG_SYN_DECAY), ONE_Q24);
        send_tick(mk_tick('0, NOISE_MAX));
        send_tick(mk_tick('0, NOISE_MIN));
        send_tick(mk_tick('0, '0));
        send_tick(mk_tick('0, ALL_ONES));
        send_tick(mk_tick('0, 32'd1));
        // decays above one, top threshold reachable only at saturation
        drain_ticks();
        write_reg(reg_addr(REG_SYN_DECAY), ALL_ONES);
        write_reg(reg_addr(REG_AHP_DECAY), ALL_ONES);
        write_reg(reg_addr(REG_CUR_PSP_GAIN), ALL_ONES);
        write_reg(reg_addr(REG_FIRE_THRESHOLD), NOISE_MAX);
        write_reg(reg_addr(REG_RESET_STEP), '0);
        write_reg(reg_addr(REG_NOISE_GAIN), ONE_Q24);
        repeat (4) send_tick(mk_tick(WEIGHT_MAX, '0));
        repeat (2) send_tick(mk_tick(WEIGHT_MAX, NOISE_MAX));
        // zero decays and gains, threshold at exactly zero
        drain_ticks();
        write_reg(reg_addr(REG_SYN_DECAY), '0);
        write_reg(reg_addr(REG_AHP_DECAY), '0);
        write_reg(reg_addr(REG_CUR_PSP_GAIN), '0);
        write_reg(reg_addr(REG_NOISE_GAIN), '0);
        write_reg(reg_addr(REG_FIRE_THRESHOLD), '0);
        send_tick(mk_tick(WEIGHT_MAX, NOISE_MAX));
        send_tick(mk_tick(31'd1, NOISE_MIN));
        repeat (2) send_tick(mk_tick('0, '0));
    endtask

    task automatic test_unmapped_writes();
        drain_ticks();
        write_reg(reg_addr(REG_FIRE_THRESHOLD), ONE_Q24);
        write_reg(ADDR_SPARE_A, ALL_ONES);
        write_reg(ADDR_SPARE_B, ALL_ONES);
        send_tick(mk_tick(WEIGHT_MAX, NOISE_MAX));
        send_tick(mk_tick(31'h0100_0000, NOISE_MIN));
        send_tick(mk_tick('0, '0));
    endtask

    task automatic test_random_ticks();
        t_reg_idx idx;
        for (int p = 0; p < PHASES; p++) begin
            drain_ticks();
            idx = idx.first();
            do begin
                write_reg(reg_addr(idx), pick_coef(idx));
                idx = idx.next();
            end while (idx != idx.first());
            // one phase runs back to back with no gaps on either side
            gaps_on = (p != 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (n == PHASE_TICKS / 2 && p % 4 == 1) begin
                    drain_ticks();
                end
                send_tick(rand_tick());
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 17);
    end

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (membrane_exp_q.size() == 0) begin
                report_mismatch("result with no tick pending", o_out_data.membrane_potential,
                                '0);
            end else begin
                want = membrane_exp_q.pop_front();
                if (o_out_data.membrane_potential !== want.membrane_potential) begin
                    report_mismatch("membrane_potential", o_out_data.membrane_potential,
                                    want.membrane_potential);
                end
                if (o_out_data.spike !== want.spike) begin
                    report_mismatch("spike", 32'(o_out_data.spike), 32'(want.spike));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lif_alpha_psp_neuron_step_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg.syn_decay = RST_SYN_DECAY;
        cfg.current_to_psp_gain = RST_CUR_PSP_GAIN;
        cfg.ahp_decay = RST_AHP_DECAY;
        cfg.fire_threshold = RST_FIRE_THRESHOLD;
        cfg.reset_step = RST_RESET_STEP;
        cfg.noise_gain = RST_NOISE_GAIN;
        syn_cur = 0;
        psp_v = 0;
        ahp_v = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_coefficients();
        test_coefficient_extremes();
        test_unmapped_writes();
        test_random_ticks();

        drain_ticks();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("lif_alpha_psp_neuron_step_tb passed");
        end else begin
            $display("lif_alpha_psp_neuron_step_tb failed");
        end
        $finish;
    end

endmodule
